// ----- hdl/zad_pkg.sv -----
// Package for the z-score anomaly detector: widths, codes, state types,
// structs passed between the top level and the arithmetic sequencer.
// No dependencies.
package zad_pkg;

   // datapath width of the shared add/subtract unit
   localparam int ALU_W       = 64;
   localparam int STORE_DEPTH = 1024;
   localparam int CNT_W       = 11;
   localparam int SUM_W       = 27;
   localparam int SQS_W       = 42;
   localparam int QM_W        = 43;
   localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

   // register indexes
   localparam logic [7:0] REG_Z_THRESHOLD      = 8'd0;
   localparam logic [7:0] REG_TRAINING_SAMPLES = 8'd1;

   // result status codes
   localparam logic [1:0] STAT_TRAIN  = 2'd0;
   localparam logic [1:0] STAT_NORMAL = 2'd1;
   localparam logic [1:0] STAT_ANOM   = 2'd2;
   localparam logic [1:0] STAT_FAKE   = 2'd3;

   typedef enum logic [3:0] {
      PH_IDLE, PH_MULA, PH_MULB, PH_SUBV, PH_SQRT, PH_MEAN, PH_STD,
      PH_MULX, PH_DIFF, PH_ABS, PH_ZDIV, PH_DONE
   } phase_type;

   typedef enum logic {
      TS_IDLE, TS_BUSY
   } top_state_type;

   // operands handed to the sequencer
   typedef struct packed {
      logic [CNT_W-1:0]        n;
      logic signed [SUM_W-1:0] s1;
      logic [SQS_W-1:0]        s2;
      logic signed [15:0]      x;
   } op_type;

   // statistics returned by the sequencer
   typedef struct packed {
      logic signed [23:0] mean;
      logic [22:0]        stdv;
      logic [QM_W-1:0]    qm;
      logic               qneg;
   } res_type;

   // one result transaction
   typedef struct packed {
      logic [1:0]         status;
      logic signed [15:0] z_score;
      logic signed [23:0] mean_out;
      logic [22:0]        std_out;
      logic [10:0]        stored_count;
      logic [31:0]        total_seen;
      logic [31:0]        normal_seen;
      logic [31:0]        anomaly_seen;
      logic [31:0]        fake_seen;
      logic               training_done;
   } rsp_type;

   function automatic logic [31:0] sat_inc(input logic [31:0] c);
      sat_inc = (c == CNT_MAX) ? c : c + 32'd1;
   endfunction

endpackage

// ----- hdl/zad_alu.sv -----
// Shared add/subtract unit of the detector datapath.
// Depends on zad_pkg.
module zad_alu (
   input  logic [zad_pkg::ALU_W-1:0] op_a,
   input  logic [zad_pkg::ALU_W-1:0] op_b,
   input  logic                      sub,
   output logic [zad_pkg::ALU_W-1:0] sum,
   output logic                      carry
);
   import zad_pkg::*;

   // carry out on subtract means op_a >= op_b
   assign {carry, sum} = {1'b0, op_a} + {1'b0, (sub ? ~op_b : op_b)}
                         + {{ALU_W{1'b0}}, sub};

endmodule

// ----- hdl/zad_seq.sv -----
// Sequencer for the detector statistics: multiplies, square root and
// divisions run one step per cycle through the shared zad_alu.
// Depends on zad_pkg and zad_alu.
module zad_seq (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  zad_pkg::op_type op,
   output logic            busy,
   output logic            done,
   output zad_pkg::res_type res
);
   import zad_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [ALU_W-1:0]  acc_ff, acc_in;
   logic [ALU_W-1:0]  aux_ff, aux_in;
   logic [ALU_W-1:0]  sh_ff, sh_in;
   logic [33:0]       r8_ff, r8_in;
   op_type            op_ff, op_in;
   res_type           res_ff, res_in;

   logic [ALU_W-1:0]  alu_a, alu_b, alu_sum;
   logic              alu_sub, alu_carry;

   logic [26:0]       s1_neg;
   logic [25:0]       mag1;
   logic [ALU_W-1:0]  s1_ext, s2_ext, x_ext, mag_ext, n_ext, r8_ext;
   logic [ALU_W-1:0]  quo_nx, rem_nx, abs_val;
   logic              dbit, remnz;
   logic [33:0]       qm_mean;

   zad_alu u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .sub   (alu_sub),
      .sum   (alu_sum),
      .carry (alu_carry)
   );

   // operand forms
   assign s1_neg  = -op_ff.s1;
   assign mag1    = op_ff.s1[SUM_W-1] ? s1_neg[25:0] : op_ff.s1[25:0];
   assign s1_ext  = {{(ALU_W-SUM_W){op_ff.s1[SUM_W-1]}}, op_ff.s1};
   assign s2_ext  = {{(ALU_W-SQS_W){1'b0}}, op_ff.s2};
   assign x_ext   = {{(ALU_W-16){op_ff.x[15]}}, op_ff.x};
   assign mag_ext = {{(ALU_W-26){1'b0}}, mag1};
   assign n_ext   = {{(ALU_W-CNT_W){1'b0}}, op_ff.n};
   assign r8_ext  = {{(ALU_W-34){1'b0}}, r8_ff};

   // restoring divide step shared by the three divisions
   assign dbit   = (phase_ff == PH_ZDIV) ? sh_ff[QM_W-1] : sh_ff[33];
   assign rem_nx = alu_carry ? alu_sum : alu_a;
   assign quo_nx = {aux_ff[ALU_W-2:0], alu_carry};
   assign remnz  = (rem_nx != '0);
   assign qm_mean = quo_nx[33:0];
   assign abs_val = acc_ff[ALU_W-1] ? alu_sum : acc_ff;

   // sequencer next state
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      acc_in   = acc_ff;
      aux_in   = aux_ff;
      sh_in    = sh_ff;
      r8_in    = r8_ff;
      op_in    = op_ff;
      res_in   = res_ff;
      alu_a    = '0;
      alu_b    = '0;
      alu_sub  = 1'b0;
      done     = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               op_in    = op;
               acc_in   = '0;
               cnt_in   = 6'd10;
               phase_in = PH_MULA;
            end
         end
         // n * S2, multiplier bits MSB first
         PH_MULA: begin
            alu_a  = acc_ff << 1;
            alu_b  = op_ff.n[cnt_ff[3:0]] ? s2_ext : '0;
            acc_in = alu_sum;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               sh_in    = alu_sum;
               acc_in   = '0;
               cnt_in   = 6'd25;
               phase_in = PH_MULB;
            end
         end
         // |S1| squared
         PH_MULB: begin
            alu_a  = acc_ff << 1;
            alu_b  = mag1[cnt_ff[4:0]] ? mag_ext : '0;
            acc_in = alu_sum;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               phase_in = PH_SUBV;
            end
         end
         // V = n*S2 - S1^2, clamped at zero
         PH_SUBV: begin
            alu_a    = sh_ff;
            alu_b    = acc_ff;
            alu_sub  = 1'b1;
            sh_in    = alu_carry ? alu_sum : '0;
            acc_in   = '0;
            aux_in   = '0;
            cnt_in   = 6'd33;
            phase_in = PH_SQRT;
         end
         // digit-by-digit root of V*65536, two bits of V per step
         PH_SQRT: begin
            alu_a   = {acc_ff[ALU_W-3:0], sh_ff[51:50]};
            alu_b   = {aux_ff[ALU_W-3:0], 2'b01};
            alu_sub = 1'b1;
            acc_in  = alu_carry ? alu_sum : alu_a;
            aux_in  = quo_nx;
            sh_in   = sh_ff << 2;
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               r8_in = quo_nx[33:0];
               if (op_ff.n == '0) begin
                  res_in.mean = '0;
                  res_in.stdv = '0;
                  acc_in      = '0;
                  cnt_in      = 6'd10;
                  phase_in    = PH_MULX;
               end else begin
                  acc_in   = '0;
                  aux_in   = '0;
                  sh_in    = {{(ALU_W-34){1'b0}}, mag1, 8'd0};
                  cnt_in   = 6'd33;
                  phase_in = PH_MEAN;
               end
            end
         end
         PH_MEAN, PH_STD, PH_ZDIV: begin
            alu_a   = {acc_ff[ALU_W-2:0], dbit};
            alu_b   = (phase_ff == PH_ZDIV) ? r8_ext : n_ext;
            alu_sub = 1'b1;
            acc_in  = rem_nx;
            aux_in  = quo_nx;
            sh_in   = sh_ff << 1;
            cnt_in  = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               case (phase_ff)
                  PH_MEAN: begin
                     // floor for negative sums
                     if (op_ff.s1[SUM_W-1]) begin
                        res_in.mean = remnz ? 24'(~qm_mean) : 24'(~qm_mean + 34'd1);
                     end else begin
                        res_in.mean = qm_mean[23:0];
                     end
                     acc_in   = '0;
                     aux_in   = '0;
                     sh_in    = r8_ext;
                     cnt_in   = 6'd33;
                     phase_in = PH_STD;
                  end
                  PH_STD: begin
                     res_in.stdv = (quo_nx[33:0] > 34'd8388607) ? 23'h7FFFFF
                                                                : quo_nx[22:0];
                     acc_in      = '0;
                     cnt_in      = 6'd10;
                     phase_in    = PH_MULX;
                  end
                  default: begin
                     res_in.qm = quo_nx[QM_W-1:0];
                     phase_in  = PH_DONE;
                  end
               endcase
            end
         end
         // x * n in two's complement
         PH_MULX: begin
            alu_a  = acc_ff << 1;
            alu_b  = op_ff.n[cnt_ff[3:0]] ? x_ext : '0;
            acc_in = alu_sum;
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd0) begin
               phase_in = PH_DIFF;
            end
         end
         // D = x*n - S1
         PH_DIFF: begin
            alu_a    = acc_ff;
            alu_b    = s1_ext;
            alu_sub  = 1'b1;
            acc_in   = alu_sum;
            phase_in = PH_ABS;
         end
         // |D|, then D*65536 / r8 unless the root r8 is zero
         PH_ABS: begin
            alu_a       = '0;
            alu_b       = acc_ff;
            alu_sub     = 1'b1;
            res_in.qneg = acc_ff[ALU_W-1];
            if (r8_ff == '0) begin
               res_in.qm = '0;
               phase_in  = PH_DONE;
            end else begin
               sh_in    = abs_val << 16;
               acc_in   = '0;
               aux_in   = '0;
               cnt_in   = 6'd42;
               phase_in = PH_ZDIV;
            end
         end
         PH_DONE: begin
            done     = 1'b1;
            phase_in = PH_IDLE;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      aux_ff <= aux_in;
      sh_ff  <= sh_in;
      r8_ff  <= r8_in;
      op_ff  <= op_in;
      res_ff <= res_in;
   end

   assign busy = (phase_ff != PH_IDLE);
   assign res  = res_ff;

endmodule

// ----- hdl/zscore_anomaly_detector_top.sv -----
// Z-score anomaly detector. Training samples (the first training_samples,
// capped at 1024) are stored and answered in the cycle after acceptance.
// Every later sample runs through one shared add/subtract unit, one step a
// cycle: n*S2, S1^2, variance, square root, mean, std, deviation and z
// division. With no stored samples mean and std are skipped; with a zero
// standard deviation the z division is skipped. The result is held in an
// output register; a new sample is taken once it is delivered.
// Depends on zad_pkg, zad_seq and zad_alu.
module zscore_anomaly_detector_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [15:0] rsp_z_score,
   output logic signed [23:0] rsp_mean_out,
   output logic [22:0]        rsp_std_out,
   output logic [10:0]        rsp_stored_count,
   output logic [31:0]        rsp_total_seen,
   output logic [31:0]        rsp_normal_seen,
   output logic [31:0]        rsp_anomaly_seen,
   output logic [31:0]        rsp_fake_seen,
   output logic               rsp_training_done,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import zad_pkg::*;

   top_state_type           state_ff, state_in;
   logic [15:0]             thr_ff;
   logic [CNT_W-1:0]        tsamp_ff;
   logic [CNT_W-1:0]        held_ff, held_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [SQS_W-1:0]        sq_ff, sq_in;
   logic [31:0]             total_ff, total_in;
   logic [31:0]             normal_ff, normal_in;
   logic [31:0]             anom_ff, anom_in;
   logic [31:0]             fake_ff, fake_in;
   logic signed [15:0]      x_ff, x_in;
   logic                    valid_ff, valid_in;
   rsp_type                 out_ff, out_in;

   logic                    seq_start, seq_busy, seq_done;
   op_type                  seq_op;
   res_type                 seq_res;
   logic [CNT_W-1:0]        limit;
   logic signed [15:0]      sq_src;
   logic signed [31:0]      sq_full;
   logic [SQS_W-1:0]        sq_add;
   logic signed [SUM_W-1:0] x_add;
   logic                    over, is_anom, is_fake;
   logic [15:0]             qm_lo_neg;
   logic signed [15:0]      z_sat;

   zad_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (seq_start),
      .op    (seq_op),
      .busy  (seq_busy),
      .done  (seq_done),
      .res   (seq_res)
   );

   assign limit = (tsamp_ff > CNT_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : tsamp_ff;

   // store path: one square shared by training and normal samples
   assign sq_src  = (state_ff == TS_IDLE) ? req_sample : x_ff;
   assign sq_full = sq_src * sq_src;
   assign sq_add  = {{(SQS_W-31){1'b0}}, sq_full[30:0]};
   assign x_add   = {{(SUM_W-16){sq_src[15]}}, sq_src};

   assign seq_op.n  = held_ff;
   assign seq_op.s1 = sum_ff;
   assign seq_op.s2 = sq_ff;
   assign seq_op.x  = req_sample;

   // classification on the raw quotient, then saturation
   assign over      = seq_res.qm > {{(QM_W-16){1'b0}}, thr_ff};
   assign is_anom   = !seq_res.qneg && over;
   assign is_fake   = seq_res.qneg && over;
   assign qm_lo_neg = -seq_res.qm[15:0];
   always_comb begin
      if (seq_res.qneg) begin
         z_sat = (seq_res.qm > QM_W'(32768)) ? 16'sh8000 : signed'(qm_lo_neg);
      end else begin
         z_sat = (seq_res.qm > QM_W'(32767)) ? 16'sh7FFF : signed'(seq_res.qm[15:0]);
      end
   end

   // transaction control and statistics update
   always_comb begin
      state_in  = state_ff;
      held_in   = held_ff;
      sum_in    = sum_ff;
      sq_in     = sq_ff;
      total_in  = total_ff;
      normal_in = normal_ff;
      anom_in   = anom_ff;
      fake_in   = fake_ff;
      x_in      = x_ff;
      out_in    = out_ff;
      valid_in  = valid_ff;
      seq_start = 1'b0;
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      case (state_ff)
         TS_IDLE: begin
            if (req_valid && !req_stall) begin
               x_in     = req_sample;
               total_in = sat_inc(total_ff);
               if (held_ff < limit) begin
                  held_in   = held_ff + CNT_W'(1);
                  sum_in    = sum_ff + x_add;
                  sq_in     = sq_ff + sq_add;
                  normal_in = sat_inc(normal_ff);
                  out_in.status        = STAT_TRAIN;
                  out_in.z_score       = '0;
                  out_in.mean_out      = '0;
                  out_in.std_out       = '0;
                  out_in.stored_count  = held_in;
                  out_in.total_seen    = total_in;
                  out_in.normal_seen   = normal_in;
                  out_in.anomaly_seen  = anom_ff;
                  out_in.fake_seen     = fake_ff;
                  out_in.training_done = (held_in >= limit);
                  valid_in = 1'b1;
               end else begin
                  seq_start = 1'b1;
                  state_in  = TS_BUSY;
               end
            end
         end
         TS_BUSY: begin
            if (seq_done) begin
               if (is_anom) begin
                  anom_in       = sat_inc(anom_ff);
                  out_in.status = STAT_ANOM;
               end else if (is_fake) begin
                  fake_in       = sat_inc(fake_ff);
                  out_in.status = STAT_FAKE;
               end else begin
                  normal_in     = sat_inc(normal_ff);
                  out_in.status = STAT_NORMAL;
                  if (held_ff < CNT_W'(STORE_DEPTH)) begin
                     held_in = held_ff + CNT_W'(1);
                     sum_in  = sum_ff + x_add;
                     sq_in   = sq_ff + sq_add;
                  end
               end
               out_in.z_score       = z_sat;
               out_in.mean_out      = seq_res.mean;
               out_in.std_out       = seq_res.stdv;
               out_in.stored_count  = held_in;
               out_in.total_seen    = total_ff;
               out_in.normal_seen   = normal_in;
               out_in.anomaly_seen  = anom_in;
               out_in.fake_seen     = fake_in;
               out_in.training_done = (held_in >= limit);
               valid_in = 1'b1;
               state_in = TS_IDLE;
            end
         end
         default: begin
            state_in = TS_IDLE;
         end
      endcase
   end

   // control and statistics state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= TS_IDLE;
         held_ff   <= '0;
         sum_ff    <= '0;
         sq_ff     <= '0;
         total_ff  <= '0;
         normal_ff <= '0;
         anom_ff   <= '0;
         fake_ff   <= '0;
         valid_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         held_ff   <= held_in;
         sum_ff    <= sum_in;
         sq_ff     <= sq_in;
         total_ff  <= total_in;
         normal_ff <= normal_in;
         anom_ff   <= anom_in;
         fake_ff   <= fake_in;
         valid_ff  <= valid_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= 16'd768;
         tsamp_ff <= CNT_W'(30);
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_Z_THRESHOLD) begin
            thr_ff <= csr_data;
         end else if (csr_index == REG_TRAINING_SAMPLES) begin
            tsamp_ff <= csr_data[CNT_W-1:0];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      out_ff <= out_in;
   end

   assign req_stall         = (state_ff != TS_IDLE) || valid_ff;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_z_score       = out_ff.z_score;
   assign rsp_mean_out      = out_ff.mean_out;
   assign rsp_std_out       = out_ff.std_out;
   assign rsp_stored_count  = out_ff.stored_count;
   assign rsp_total_seen    = out_ff.total_seen;
   assign rsp_normal_seen   = out_ff.normal_seen;
   assign rsp_anomaly_seen  = out_ff.anomaly_seen;
   assign rsp_fake_seen     = out_ff.fake_seen;
   assign rsp_training_done = out_ff.training_done;

   // sequencer activity only while a transaction is in flight
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      seq_busy |-> req_stall)
      else $error("sequencer busy while input open");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      seq_done |-> (state_ff == TS_BUSY))
      else $error("sequencer done outside busy state");

   a_held_depth: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_W'(STORE_DEPTH))
      else $error("stored count beyond depth");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      seq_start |=> seq_busy)
      else $error("sequencer did not start");

endmodule

// ----- verif/tb_zscore_anomaly_detector_top.sv -----
// Self-checking testbench for zscore_anomaly_detector_top: random and directed samples,
// a built-in z-score predictor, and a field-by-field check of every result.
// Depends on zad_pkg and the detector RTL.
module tb_zscore_anomaly_detector_top;
   import zad_pkg::*;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [15:0] req_sample;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_status;
   logic signed [15:0] rsp_z_score;
   logic signed [23:0] rsp_mean_out;
   logic [22:0]        rsp_std_out;
   logic [10:0]        rsp_stored_count;
   logic [31:0]        rsp_total_seen;
   logic [31:0]        rsp_normal_seen;
   logic [31:0]        rsp_anomaly_seen;
   logic [31:0]        rsp_fake_seen;
   logic               rsp_training_done;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [15:0]        csr_data;

   localparam int WATCHDOG_LIMIT = 20000;

   zscore_anomaly_detector_top uut (.*);

   // predictor copy of the detector state and registers
   logic [15:0] thr_q88;
   logic [10:0] train_cfg;
   int unsigned held_n;
   longint      sum_x;
   bit [63:0]   sum_xx;
   logic [31:0] cnt_total, cnt_normal, cnt_anom, cnt_fake;

   logic signed [15:0] sample_queue[$];
   rsp_type            expected_rsp[$];
   int                 mismatches;
   int                 samples_taken;
   int                 results_seen;
   int                 send_idle_pct, recv_idle_pct;
   int                 hold_left;
   bit                 hold_done;
   bit                 taken;
   int                 quiet_cycles;

   // empty statistics, zero deviation and full-scale extremes
   logic signed [15:0] corner_samples[8] = '{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sd0,
                                             16'sd1, -16'sd1, 16'sh7FFF, 16'sh8000};

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit [63:0] root_q88(input bit [63:0] v);
      bit [63:0] rem, root, trial, pair;
      rem  = 0;
      root = 0;
      for (int i = 0; i < 40; i++) begin
         pair  = (i < 32) ? ((v >> (62 - 2 * i)) & 64'd3) : 64'd0;
         rem   = (rem << 2) | pair;
         trial = (root << 2) | 64'd1;
         root  = root << 1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = root | 64'd1;
         end
      end
      return root;
   endfunction

   function automatic int unsigned train_limit();
      return (train_cfg > STORE_DEPTH) ? STORE_DEPTH : train_cfg;
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   // score one sample, update the statistics, queue the expected result
   function automatic void score_sample(input logic signed [15:0] s);
      rsp_type   r;
      longint    x, n, num, mean, q, d, mag1;
      bit [63:0] a, b, v, r8, stdv, dm, qm;
      x = s;
      mean = 0;
      stdv = 0;
      q = 0;
      cnt_total = bump(cnt_total);
      if (held_n < train_limit()) begin
         held_n++;
         sum_x += x;
         sum_xx += x * x;
         cnt_normal = bump(cnt_normal);
         r.status = STAT_TRAIN;
      end else begin
         n    = held_n;
         mag1 = (sum_x < 0) ? -sum_x : sum_x;
         a    = n * sum_xx;
         b    = mag1 * mag1;
         v    = (a > b) ? a - b : 64'd0;
         r8   = root_q88(v);
         if (n > 0) begin
            num  = sum_x * 256;
            mean = num / n;
            if ((num % n) != 0 && num < 0) mean = mean - 1;
            stdv = r8 / n;
            if (stdv > 64'd8388607) stdv = 64'd8388607;
         end
         if (r8 != 0) begin
            d  = x * n - sum_x;
            dm = (d < 0) ? -d : d;
            qm = (dm << 16) / r8;
            q  = (d < 0) ? -longint'(qm) : longint'(qm);
         end
         if (q > longint'(thr_q88)) begin
            r.status = STAT_ANOM;
            cnt_anom = bump(cnt_anom);
         end else if (q < -longint'(thr_q88)) begin
            r.status = STAT_FAKE;
            cnt_fake = bump(cnt_fake);
         end else begin
            r.status = STAT_NORMAL;
            cnt_normal = bump(cnt_normal);
            if (held_n < STORE_DEPTH) begin
               held_n++;
               sum_x += x;
               sum_xx += x * x;
            end
         end
         if (q > 32767) q = 32767;
         if (q < -32768) q = -32768;
      end
      r.z_score       = q[15:0];
      r.mean_out      = mean[23:0];
      r.std_out       = stdv[22:0];
      r.stored_count  = held_n[10:0];
      r.total_seen    = cnt_total;
      r.normal_seen   = cnt_normal;
      r.anomaly_seen  = cnt_anom;
      r.fake_seen     = cnt_fake;
      r.training_done = (held_n >= train_limit());
      expected_rsp.push_back(r);
   endfunction

   // mostly a tight cluster, sometimes outliers and full-range values
   function automatic logic signed [15:0] pick_sample();
      int k;
      k = $urandom_range(99);
      if (k < 70) return 16'sd1000 + $signed(16'($urandom_range(400))) - 16'sd200;
      if (k < 80) return 16'sd1000 + $signed(16'($urandom_range(8000))) - 16'sd4000;
      if (k < 85) return ($urandom_range(1)) ? 16'sh7FFF : 16'sh8000;
      return 16'($urandom);
   endfunction

   // sample driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_sample <= '0;
      end else if (!req_valid || taken) begin
         if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_sample <= sample_queue[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
      taken = 1'b0;
   end

   // accepted sample: predict and change idle regime by progress
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         void'(sample_queue.pop_front());
         score_sample(req_sample);
         taken = 1'b1;
         samples_taken++;
         if (samples_taken == 150) begin
            send_idle_pct = 66;
            recv_idle_pct = 28;
         end else if (samples_taken == 300) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      end
   end

   // result stall generation, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && results_seen == 60) begin
         hold_done = 1'b1;
         hold_left = 400;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // result monitor
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (expected_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction, status %0d", rsp_status);
         end else begin
            e = expected_rsp.pop_front();
            if (e.status !== rsp_status || e.z_score !== rsp_z_score ||
                e.mean_out !== rsp_mean_out || e.std_out !== rsp_std_out ||
                e.stored_count !== rsp_stored_count || e.total_seen !== rsp_total_seen ||
                e.normal_seen !== rsp_normal_seen || e.anomaly_seen !== rsp_anomaly_seen ||
                e.fake_seen !== rsp_fake_seen || e.training_done !== rsp_training_done) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result %0d exp st=%0d z=%0d m=%0d sd=%0d n=%0d t=%0d nr=%0d a=%0d f=%0d d=%0d",
                           results_seen, e.status, e.z_score, e.mean_out, e.std_out,
                           e.stored_count, e.total_seen, e.normal_seen, e.anomaly_seen,
                           e.fake_seen, e.training_done);
                  $display("   got st=%0d z=%0d m=%0d sd=%0d n=%0d t=%0d nr=%0d a=%0d f=%0d d=%0d",
                           rsp_status, rsp_z_score, rsp_mean_out, rsp_std_out,
                           rsp_stored_count, rsp_total_seen, rsp_normal_seen,
                           rsp_anomaly_seen, rsp_fake_seen, rsp_training_done);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_zscore_anomaly_detector_top: done, errors");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_Z_THRESHOLD) thr_q88 = val;
      else if (idx == REG_TRAINING_SAMPLES) train_cfg = val[10:0];
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      while (sample_queue.size() > 0 || req_valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic push_random(input int count);
      repeat (count) sample_queue.push_back(pick_sample());
   endtask

   // stimulus
   initial begin
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      thr_q88 = 16'd768;
      train_cfg = 11'd30;
      held_n = 0;
      sum_x = 0;
      sum_xx = 0;
      cnt_total = 0;
      cnt_normal = 0;
      cnt_anom = 0;
      cnt_fake = 0;
      mismatches = 0;
      samples_taken = 0;
      results_seen = 0;
      send_idle_pct = 28;
      recv_idle_pct = 66;
      hold_left = 0;
      hold_done = 1'b0;
      taken = 1'b0;
      quiet_cycles = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no training: empty statistics, then zero deviation, then extremes
      write_reg(REG_TRAINING_SAMPLES, 16'd0);
      foreach (corner_samples[i])
         sample_queue.push_back(corner_samples[i]);
      drain();

      // normal training run, default threshold
      write_reg(REG_TRAINING_SAMPLES, 16'd30);
      write_reg(REG_Z_THRESHOLD, 16'd768);
      push_random(160);
      drain();

      // zero threshold, widest threshold, then a tight one
      write_reg(REG_Z_THRESHOLD, 16'd0);
      push_random(50);
      drain();
      write_reg(REG_Z_THRESHOLD, 16'hFFFF);
      push_random(50);
      drain();
      write_reg(REG_Z_THRESHOLD, 16'd256);
      push_random(80);
      drain();

      // training limit past the store depth
      write_reg(REG_TRAINING_SAMPLES, 16'h07FF);
      write_reg(REG_Z_THRESHOLD, 16'hFFFF);
      push_random(40);
      drain();

      // out-of-range index is ignored; finish on a training limit of 1024 and the default threshold
      write_reg(8'd7, 16'h0001);
      write_reg(REG_TRAINING_SAMPLES, 16'd1024);
      write_reg(REG_Z_THRESHOLD, 16'd768);
      push_random(60);
      drain();
      repeat (300) @(posedge clock);

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("tb_zscore_anomaly_detector_top: done, clean");
      end else begin
         $display("tb_zscore_anomaly_detector_top: done, errors");
      end
      $finish;
   end
endmodule
